FILE: hdl/page_framebuffer_draw_engine_defines.svh
// assertion macros for the page framebuffer draw engine
// used by the top level only, expects i_clk and i_rst_n in scope
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_DEFINES_SVH

// property must hold at every edge outside reset
`define PFDE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define PFDE_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

FILE: hdl/pfde_pkg.sv
// shared types, constants and helper functions for the draw engine
// no dependencies
package pfde_pkg;

    localparam int SCREEN_WIDTH_DEF = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;
    localparam int CHUNK_BYTES_DEF = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

    // largest store is 256 columns by 32 pages
    localparam int OP_ADDR_W = 13;
    localparam int IN_DATA_W = 48;
    localparam int IN_USER_W = 3;

    typedef enum logic [2:0] {
        CMD_PIXEL  = 3'd0,
        CMD_HLINE  = 3'd1,
        CMD_VLINE  = 3'd2,
        CMD_DASHED = 3'd3,
        CMD_CLEAR  = 3'd4,
        CMD_READ   = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        OP_HLINE = 2'd0,
        OP_VLINE = 2'd1,
        OP_FILL  = 2'd2,
        OP_READ  = 2'd3
    } t_op_kind;

    typedef struct packed {
        t_op_kind               kind;
        logic [OP_ADDR_W-1:0]   addr;
        logic [OP_ADDR_W-1:0]   rem;      // bytes to touch minus one
        logic [7:0]             mask;     // bit mask for a horizontal span
        logic [7:0]             row_lo;
        logic [7:0]             row_hi;
        logic [1:0]             top_mod3; // first page top row mod 3
        logic                   dashed;
        logic                   on;
    } t_op;

    typedef struct packed {
        logic       s2_read;
        logic [1:0] ob_cnt;
    } t_back_stat;

    function automatic logic [1:0] mod3_u4(input logic [3:0] v);
        logic [1:0] r;
        unique case (v)
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: r = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       r = 2'd1;
            default:                              r = 2'd2;
        endcase
        return r;
    endfunction

    // 4 = 1 mod 3, so the base-4 digit sum keeps the residue
    function automatic logic [1:0] mod3_u8(input logic [7:0] v);
        logic [3:0] s;
        s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
        return mod3_u4(s);
    endfunction

endpackage

FILE: hdl/pfde_queue.sv
// small register fifo of decoded drawing ops between front and back
// depends on pfde_pkg for the op type
module pfde_queue import pfde_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output t_op  o_op,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_op              r_mem [DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_op    = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PTR_W'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == PTR_W'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_op;
        end
    end

endmodule

FILE: hdl/pfde_front.sv
// command front end: takes items, clips coordinates, builds byte-span ops
// depends on pfde_pkg
module pfde_front import pfde_pkg::*; #(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
    parameter int CHUNK_BYTES   = CHUNK_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // x_a, x_b, y_a, y_b, pixel_on, chunk_index, zero fill
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    // cmd
    input  logic [IN_USER_W-1:0] s_axis_tuser,
    output logic                 o_push,
    output t_op                  o_op,
    input  logic                 i_full
);

    localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE = SCREEN_WIDTH * PAGES;
    localparam logic signed [9:0] XMAX = 10'(SCREEN_WIDTH - 1);
    localparam logic signed [9:0] YMAX = 10'(SCREEN_HEIGHT - 1);

    logic               r_valid;
    t_cmd               r_cmd;
    logic signed [9:0]  r_xa, r_xb, r_ya, r_yb;
    logic               r_on;
    logic [3:0]         r_chunk;

    logic signed [9:0]  hx_lo, hx_hi, vy_lo, vy_hi;
    logic               h_vis, v_vis, is_h, keep, done;
    logic [7:0]         h_clo, h_chi, v_clo, v_chi;
    logic [4:0]         sel_page;
    logic [7:0]         sel_col;
    logic [13:0]        addr_full, rd_start, rd_left, rd_n;
    logic               rd_ok;

    always_comb begin
        hx_lo = (r_cmd == CMD_PIXEL) ? r_xa : ((r_xa < r_xb) ? r_xa : r_xb);
        hx_hi = (r_cmd == CMD_PIXEL) ? r_xa : ((r_xa < r_xb) ? r_xb : r_xa);
        vy_lo = (r_ya < r_yb) ? r_ya : r_yb;
        vy_hi = (r_ya < r_yb) ? r_yb : r_ya;

        h_vis = !r_ya[9] && (r_ya <= YMAX) && !hx_hi[9] && (hx_lo <= XMAX);
        v_vis = !r_xa[9] && (r_xa <= XMAX) && !vy_hi[9] && (vy_lo <= YMAX);

        h_clo = hx_lo[9] ? 8'd0 : hx_lo[7:0];
        h_chi = (hx_hi > XMAX) ? XMAX[7:0] : hx_hi[7:0];
        v_clo = vy_lo[9] ? 8'd0 : vy_lo[7:0];
        v_chi = (vy_hi > YMAX) ? YMAX[7:0] : vy_hi[7:0];

        is_h     = (r_cmd == CMD_PIXEL) || (r_cmd == CMD_HLINE);
        sel_page = is_h ? r_ya[7:3] : v_clo[7:3];
        sel_col  = is_h ? h_clo : r_xa[7:0];
        addr_full = 14'(sel_page) * 14'(SCREEN_WIDTH) + 14'(sel_col);

        rd_start = 14'(r_chunk) * 14'(CHUNK_BYTES);
        rd_ok    = rd_start < 14'(STORE);
        rd_left  = 14'(STORE) - rd_start;
        rd_n     = (rd_left > 14'(CHUNK_BYTES)) ? 14'(CHUNK_BYTES) : rd_left;
    end

    always_comb begin
        o_op          = '0;
        o_op.kind     = OP_HLINE;
        o_op.addr     = addr_full[OP_ADDR_W-1:0];
        o_op.mask     = 8'd1 << r_ya[2:0];
        o_op.row_lo   = v_clo;
        o_op.row_hi   = v_chi;
        o_op.top_mod3 = mod3_u8({v_clo[7:3], 3'b000});
        o_op.dashed   = (r_cmd == CMD_DASHED);
        o_op.on       = (r_cmd == CMD_DASHED) ? 1'b1 : r_on;
        keep          = 1'b0;
        unique case (r_cmd)
            CMD_PIXEL, CMD_HLINE: begin
                keep     = h_vis;
                o_op.rem = OP_ADDR_W'(h_chi - h_clo);
            end
            CMD_VLINE, CMD_DASHED: begin
                keep      = v_vis;
                o_op.kind = OP_VLINE;
                o_op.rem  = OP_ADDR_W'(v_chi[7:3] - v_clo[7:3]);
            end
            CMD_CLEAR: begin
                keep      = 1'b1;
                o_op.kind = OP_FILL;
                o_op.addr = '0;
                o_op.mask = 8'hFF;
                o_op.on   = 1'b0;
                o_op.rem  = OP_ADDR_W'(STORE - 1);
            end
            CMD_READ: begin
                keep      = rd_ok;
                o_op.kind = OP_READ;
                o_op.addr = rd_start[OP_ADDR_W-1:0];
                o_op.rem  = OP_ADDR_W'(rd_n - 14'd1);
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    // items that draw nothing retire without touching the queue
    assign done          = r_valid && (!keep || !i_full);
    assign o_push        = r_valid && keep && !i_full;
    assign s_axis_tready = !r_valid || done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_valid <= 1'b1;
        end else if (done) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd   <= t_cmd'(s_axis_tuser);
            r_xa    <= s_axis_tdata[9:0];
            r_xb    <= s_axis_tdata[19:10];
            r_ya    <= s_axis_tdata[29:20];
            r_yb    <= s_axis_tdata[39:30];
            r_on    <= s_axis_tdata[40];
            r_chunk <= s_axis_tdata[44:41];
        end
    end

endmodule

FILE: hdl/pfde_back.sv
// back end: walks byte-span ops over the frame memory with read-modify-write,
// streams readout bytes through a two-entry output buffer; depends on pfde_pkg
module pfde_back import pfde_pkg::*; #(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_op        i_op,
    input  logic       i_op_valid,
    output logic       o_pop,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    // data_byte
    output logic [7:0] m_axis_tdata,
    output logic       m_axis_tlast,
    output t_back_stat o_stat
);

    localparam int PAGES  = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE  = SCREEN_WIDTH * PAGES;
    localparam int ADDR_W = $clog2(STORE);

    logic [7:0]           mem [STORE];

    // sequencer
    logic                 r_act;
    t_op_kind             r_kind;
    logic [ADDR_W-1:0]    r_addr;
    logic [OP_ADDR_W-1:0] r_rem;
    logic [7:0]           r_mask, r_row_lo, r_row_hi, r_top;
    logic [1:0]           r_mod3;
    logic                 r_dashed, r_on;

    // read-modify-write stage
    logic                 r_s2_valid, r_s2_read, r_s2_on, r_s2_last;
    logic [ADDR_W-1:0]    r_s2_addr;
    logic [7:0]           r_s2_mask, r_rd_data, r_fwd_data;
    logic                 r_fwd;

    // output buffer
    logic [7:0]           r_ob_data [2];
    logic                 r_ob_last [2];
    logic                 r_ob_wp, r_ob_rp;
    logic [1:0]           r_ob_cnt;

    logic                 issue, room, ob_pop, ob_push, w_en;
    logic [2:0]           ob_next;
    logic [7:0]           cur, w_data, vmask, cur_mask, row;

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            row      = r_top + 8'(b);
            vmask[b] = (row >= r_row_lo) && (row <= r_row_hi) &&
                       (!r_dashed || (mod3_u4(4'(r_mod3) + 4'(b)) == 2'd0));
        end
        if (r_kind == OP_VLINE) begin
            cur_mask = vmask;
        end else begin
            cur_mask = r_mask;
        end
    end

    assign ob_pop  = m_axis_tvalid && m_axis_tready;
    assign ob_push = r_s2_valid && r_s2_read;
    assign ob_next = 3'(r_ob_cnt) + 3'(ob_push) - 3'(ob_pop);
    assign room    = ob_next < 3'd2;
    assign issue   = r_act && ((r_kind != OP_READ) || room);
    assign o_pop   = !r_act && i_op_valid;

    assign cur    = r_fwd ? r_fwd_data : r_rd_data;
    assign w_en   = r_s2_valid && !r_s2_read;
    assign w_data = r_s2_on ? (cur | r_s2_mask) : (cur & ~r_s2_mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // reset starts a fill sweep that zeroes the whole store
            r_act    <= 1'b1;
            r_kind   <= OP_FILL;
            r_addr   <= '0;
            r_rem    <= OP_ADDR_W'(STORE - 1);
            r_mask   <= 8'hFF;
            r_on     <= 1'b0;
            r_dashed <= 1'b0;
        end else if (o_pop) begin
            r_act    <= 1'b1;
            r_kind   <= i_op.kind;
            r_addr   <= i_op.addr[ADDR_W-1:0];
            r_rem    <= i_op.rem;
            r_mask   <= i_op.mask;
            r_on     <= i_op.on;
            r_dashed <= i_op.dashed;
            r_row_lo <= i_op.row_lo;
            r_row_hi <= i_op.row_hi;
            r_top    <= {i_op.row_lo[7:3], 3'b000};
            r_mod3   <= i_op.top_mod3;
        end else if (issue) begin
            if (r_rem == '0) begin
                r_act <= 1'b0;
            end
            r_rem <= r_rem - 1'b1;
            if (r_kind == OP_VLINE) begin
                r_addr <= r_addr + ADDR_W'(SCREEN_WIDTH);
                r_top  <= r_top + 8'd8;
                r_mod3 <= mod3_u4(4'(r_mod3) + 4'd2);
            end else begin
                r_addr <= r_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s2_read  <= (r_kind == OP_READ);
            r_s2_addr  <= r_addr;
            r_s2_mask  <= cur_mask;
            r_s2_on    <= r_on;
            r_s2_last  <= (r_rem == '0);
            // byte written this cycle is newer than what the read returns
            r_fwd      <= w_en && (r_s2_addr == r_addr);
            r_fwd_data <= w_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[r_s2_addr] <= w_data;
        end
        if (issue) begin
            r_rd_data <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_wp  <= 1'b0;
            r_ob_rp  <= 1'b0;
            r_ob_cnt <= 2'd0;
        end else begin
            r_ob_cnt <= ob_next[1:0];
            if (ob_push) begin
                r_ob_wp <= !r_ob_wp;
            end
            if (ob_pop) begin
                r_ob_rp <= !r_ob_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ob_push) begin
            r_ob_data[r_ob_wp] <= cur;
            r_ob_last[r_ob_wp] <= r_s2_last;
        end
    end

    assign m_axis_tvalid = (r_ob_cnt != 2'd0);
    assign m_axis_tdata  = r_ob_data[r_ob_rp];
    assign m_axis_tlast  = r_ob_last[r_ob_rp];

    assign o_stat.s2_read = ob_push;
    assign o_stat.ob_cnt  = r_ob_cnt;

endmodule

FILE: hdl/page_framebuffer_draw_engine.sv
// throughput: one frame byte per cycle in the back end, unless a readout waits for room
// in the output buffer; a pixel or span of n columns touches n bytes, a vertical line one
// byte per page touched, a readout one chunk of up to 64 bytes by default, a clear every
// store byte (1024 by default); reset: synchronous active low; afterwards a fill sweep
// over every store byte zeroes the memory, while up to five items (with the default queue
// depth) are taken in and wait
`include "page_framebuffer_draw_engine_defines.svh"
module page_framebuffer_draw_engine import pfde_pkg::*; #(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
    parameter int CHUNK_BYTES   = CHUNK_BYTES_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // x_a[9:0], x_b[19:10], y_a[29:20], y_b[39:30], pixel_on[40], chunk_index[44:41]
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    // cmd
    input  logic [IN_USER_W-1:0] s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // data_byte
    output logic [7:0]           m_axis_tdata,
    output logic                 m_axis_tlast
);

    logic       q_push, q_full, q_pop, q_empty;
    t_op        q_in, q_out;
    t_back_stat bk_stat;

    pfde_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .CHUNK_BYTES   (CHUNK_BYTES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_push        (q_push),
        .o_op          (q_in),
        .i_full        (q_full)
    );

    pfde_queue #(
        .DEPTH   (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_op    (q_out),
        .o_empty (q_empty)
    );

    pfde_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (q_out),
        .i_op_valid    (!q_empty),
        .o_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .o_stat        (bk_stat)
    );

    `PFDE_ASSERT_NEVER(a_queue_overflow, q_push && q_full, "op pushed into a full queue")
    `PFDE_ASSERT_NEVER(a_queue_underflow, q_pop && q_empty, "op popped from an empty queue")
    `PFDE_ASSERT(a_ob_room, bk_stat.s2_read |-> bk_stat.ob_cnt != 2'd2, "output buffer overrun")

endmodule
